[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define MEC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication checked outside reset.
`define MEC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/mec_pkg.sv]
package mec_pkg;

   // Defaults for the top-level parameters
   localparam int VERTEX_BITS_DEF = 16;
   localparam int TABLE_DEPTH_DEF = 4096;

   // Fixed field widths
   localparam int IN_BITS    = 16;
   localparam int TOTAL_BITS = 13;
   localparam int HASH_BITS  = 32;

   // Edge hash multiplier
   localparam logic [HASH_BITS-1:0] HASH_MULT = 32'd1315423911;

   // Use count codes
   localparam logic [1:0] USE_ONE = 2'd1;
   localparam logic [1:0] USE_TWO = 2'd2;
   localparam logic [1:0] USE_MAX = 2'd3;

   // Edge order within a triangle: (a,b), (b,c), (c,a)
   localparam logic [1:0] EDGE_FIRST  = 2'd0;
   localparam logic [1:0] EDGE_SECOND = 2'd1;
   localparam logic [1:0] EDGE_LAST   = 2'd2;

   // Slot epoch marks: a slot is live when its mark equals the current epoch
   localparam int EPOCH_BITS = 4;
   localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = 4'd1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

   // Edge queue depth between front and back
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [IN_BITS-1:0] vertex_a;
      logic [IN_BITS-1:0] vertex_b;
      logic [IN_BITS-1:0] vertex_c;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic                  watertight;
      logic                  manifold;
      logic [TOTAL_BITS-1:0] edge_total;
      logic                  table_full;
   } rsp_type;

   typedef struct packed {
      logic restart;
      logic last;
   } edge_flags_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_ADD,
      F_MOD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_SWEEP,
      B_IDLE,
      B_READ,
      B_CHECK,
      B_RESULT
   } back_state_type;

endpackage

[rtl/mec_ram.sv]
module mec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/mec_front.sv]
module mec_front #(
   parameter int VERTEX_BITS = mec_pkg::VERTEX_BITS_DEF,
   parameter int TABLE_DEPTH = mec_pkg::TABLE_DEPTH_DEF,
   localparam int VW = (VERTEX_BITS < mec_pkg::IN_BITS) ? VERTEX_BITS : mec_pkg::IN_BITS,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hold,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mec_pkg::req_type        req_data,
   output logic                    push_valid,
   input  logic                    push_ready,
   output mec_pkg::edge_flags_type push_flags,
   output logic [2*VW-1:0]         push_key,
   output logic [AW-1:0]           push_slot
);

   localparam int  HB      = mec_pkg::HASH_BITS;
   localparam bit  IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
   // floor(2^32 / depth): quotient estimate is low by at most one
   localparam logic [HB-1:0] RECIP = HB'((64'd1 << HB) / 64'(TABLE_DEPTH));

   // Remainder steps
   localparam logic [1:0] MOD_QUOT = 2'd0;
   localparam logic [1:0] MOD_SUB  = 2'd1;
   localparam logic [1:0] MOD_FIX  = 2'd2;

   mec_pkg::front_state_type state_ff, state_in;

   logic [VW-1:0] va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in;
   logic          restart_ff, restart_in;
   logic [1:0]    edge_ff, edge_in;
   logic [VW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [HB-1:0] prod_ff, prod_in, sum_ff, sum_in;
   logic [HB-1:0] quot_ff, quot_in;
   logic [AW:0]   rem_ff, rem_in;
   logic [1:0]    step_ff, step_in;
   logic [AW-1:0] slot_ff, slot_in;

   logic [VW-1:0]   p_sel, q_sel, ord_lo, ord_hi;
   logic [HB-1:0]   hash;
   logic [2*HB-1:0] recip_prod;
   logic [AW-1:0]   rem_fix;

   // Pick the current edge and put it in order
   always_comb begin
      case (edge_ff)
         mec_pkg::EDGE_FIRST: begin
            p_sel = va_ff;
            q_sel = vb_ff;
         end
         mec_pkg::EDGE_SECOND: begin
            p_sel = vb_ff;
            q_sel = vc_ff;
         end
         default: begin
            p_sel = vc_ff;
            q_sel = va_ff;
         end
      endcase
      ord_lo = (q_sel < p_sel) ? q_sel : p_sel;
      ord_hi = (q_sel < p_sel) ? p_sel : q_sel;
   end

   // Hash, then (for a depth that is not a power of two) remainder by reciprocal multiply and one correction
   assign hash       = prod_ff + HB'(hi_ff);
   assign recip_prod = (2*HB)'(sum_ff) * (2*HB)'(RECIP);
   assign rem_fix    = (rem_ff >= (AW+1)'(TABLE_DEPTH)) ?
                       AW'(rem_ff - (AW+1)'(TABLE_DEPTH)) : rem_ff[AW-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mec_pkg::F_IDLE: if (req_valid && !hold) state_in = mec_pkg::F_MUL;
         mec_pkg::F_MUL:  state_in = mec_pkg::F_ADD;
         mec_pkg::F_ADD:  state_in = IS_POW2 ? mec_pkg::F_PUSH : mec_pkg::F_MOD;
         mec_pkg::F_MOD:  if (step_ff == MOD_FIX) state_in = mec_pkg::F_PUSH;
         mec_pkg::F_PUSH: begin
            if (push_ready) begin
               state_in = (edge_ff == mec_pkg::EDGE_LAST) ? mec_pkg::F_IDLE : mec_pkg::F_MUL;
            end
         end
         default: state_in = mec_pkg::F_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      va_in      = va_ff;
      vb_in      = vb_ff;
      vc_in      = vc_ff;
      restart_in = restart_ff;
      edge_in    = edge_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      slot_in    = slot_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         mec_pkg::F_IDLE: begin
            req_ready = !hold;
            if (req_valid && !hold) begin
               va_in      = req_data.vertex_a[VW-1:0];
               vb_in      = req_data.vertex_b[VW-1:0];
               vc_in      = req_data.vertex_c[VW-1:0];
               restart_in = req_data.restart;
               edge_in    = mec_pkg::EDGE_FIRST;
            end
         end
         mec_pkg::F_MUL: begin
            lo_in   = ord_lo;
            hi_in   = ord_hi;
            prod_in = HB'(ord_lo) * mec_pkg::HASH_MULT;
         end
         mec_pkg::F_ADD: begin
            sum_in  = hash;
            slot_in = hash[AW-1:0];
            rem_in  = '0;
            step_in = MOD_QUOT;
         end
         mec_pkg::F_MOD: begin
            case (step_ff)
               MOD_QUOT: quot_in = recip_prod[2*HB-1:HB];
               MOD_SUB:  rem_in  = (AW+1)'(sum_ff - quot_ff * HB'(TABLE_DEPTH));
               default:  slot_in = rem_fix;
            endcase
            step_in = step_ff + 1'b1;
         end
         mec_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) edge_in = edge_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign push_flags.restart = restart_ff && (edge_ff == mec_pkg::EDGE_FIRST);
   assign push_flags.last    = (edge_ff == mec_pkg::EDGE_LAST);
   assign push_key           = {lo_ff, hi_ff};
   assign push_slot          = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mec_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      vc_ff      <= vc_in;
      restart_ff <= restart_in;
      edge_ff    <= edge_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      slot_ff    <= slot_in;
   end

endmodule

[rtl/mec_fifo.sv]
`include "assert_macros.svh"

module mec_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mec_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   `MEC_ASSERT(a_fill_bound, clock, reset, count_ff <= CW'(DEPTH), "queue fill above depth")

endmodule

[rtl/mec_back.sv]
`include "assert_macros.svh"

module mec_back #(
   parameter int VERTEX_BITS = mec_pkg::VERTEX_BITS_DEF,
   parameter int TABLE_DEPTH = mec_pkg::TABLE_DEPTH_DEF,
   localparam int VW = (VERTEX_BITS < mec_pkg::IN_BITS) ? VERTEX_BITS : mec_pkg::IN_BITS,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    sweeping,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  mec_pkg::edge_flags_type pop_flags,
   input  logic [2*VW-1:0]         pop_key,
   input  logic [AW-1:0]           pop_slot,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mec_pkg::rsp_type        rsp_data
);

   localparam int EB = mec_pkg::EPOCH_BITS;
   localparam int KW = 2 * VW;
   localparam int RW = EB + KW + 2;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_DEPTH - 1);

   mec_pkg::back_state_type state_ff, state_in;

   logic [EB-1:0] epoch_ff, epoch_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          held_ff, held_in;
   logic [KW-1:0] key_ff, key_in;
   logic [AW-1:0] slot_ff, slot_in, probe_ff, probe_in;
   logic          last_ff, last_in;
   logic [CW-1:0] distinct_ff, distinct_in, twice_ff, twice_in, over_ff, over_in;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff, rsp_valid_in;
   mec_pkg::rsp_type rsp_ff, rsp_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [RW-1:0] ram_wdata, ram_rdata;

   logic [EB-1:0] rd_epoch;
   logic [KW-1:0] rd_key;
   logic [1:0]    rd_use, use_sat;
   logic          slot_free, slot_match, exhausted, edge_done, rsp_load;
   logic [AW-1:0] slot_next;
   logic [CW:0]   used_sum;

   mec_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Probe decode: free slot, key hit, table exhausted, or move on
   assign rd_epoch   = ram_rdata[RW-1 -: EB];
   assign rd_key     = ram_rdata[2 +: KW];
   assign rd_use     = ram_rdata[1:0];
   assign use_sat    = (rd_use == mec_pkg::USE_MAX) ? mec_pkg::USE_MAX : rd_use + 1'b1;
   assign slot_free  = (rd_epoch != epoch_ff);
   assign slot_match = !slot_free && (rd_key == key_ff);
   assign exhausted  = (probe_ff == SLOT_LAST);
   assign edge_done  = slot_free || slot_match || exhausted;
   assign slot_next  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
   assign rsp_load   = !rsp_valid_ff || rsp_ready;
   assign sweeping   = (state_ff == mec_pkg::B_SWEEP);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mec_pkg::B_SWEEP: begin
            if (sweep_ff == SLOT_LAST) state_in = held_ff ? mec_pkg::B_READ : mec_pkg::B_IDLE;
         end
         mec_pkg::B_IDLE: begin
            if (pop_valid) begin
               if (pop_flags.restart && (epoch_ff == mec_pkg::EPOCH_LAST)) begin
                  state_in = mec_pkg::B_SWEEP;
               end else begin
                  state_in = mec_pkg::B_READ;
               end
            end
         end
         mec_pkg::B_READ: state_in = mec_pkg::B_CHECK;
         mec_pkg::B_CHECK: begin
            if (edge_done) state_in = last_ff ? mec_pkg::B_RESULT : mec_pkg::B_IDLE;
         end
         mec_pkg::B_RESULT: if (rsp_load) state_in = mec_pkg::B_IDLE;
         default: state_in = mec_pkg::B_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      held_in      = held_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      last_in      = last_ff;
      distinct_in  = distinct_ff;
      twice_in     = twice_ff;
      over_in      = over_ff;
      overflow_in  = overflow_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = slot_ff;
      ram_wdata    = {epoch_ff, key_ff, mec_pkg::USE_ONE};
      ram_re       = 1'b0;
      ram_raddr    = slot_ff;
      case (state_ff)
         mec_pkg::B_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = {mec_pkg::EPOCH_CLEAR, {(KW + 2){1'b0}}};
            sweep_in  = sweep_ff + 1'b1;
         end
         mec_pkg::B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               key_in   = pop_key;
               slot_in  = pop_slot;
               last_in  = pop_flags.last;
               probe_in = '0;
               held_in  = 1'b1;
               if (pop_flags.restart) begin
                  distinct_in = '0;
                  twice_in    = '0;
                  over_in     = '0;
                  overflow_in = 1'b0;
                  if (epoch_ff == mec_pkg::EPOCH_LAST) begin
                     epoch_in = mec_pkg::EPOCH_FIRST;
                     sweep_in = '0;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         mec_pkg::B_READ: ram_re = 1'b1;
         mec_pkg::B_CHECK: begin
            if (slot_free) begin
               ram_we      = 1'b1;
               distinct_in = distinct_ff + 1'b1;
               held_in     = 1'b0;
            end else if (slot_match) begin
               ram_we    = 1'b1;
               ram_wdata = {epoch_ff, key_ff, use_sat};
               if (rd_use == mec_pkg::USE_ONE) begin
                  twice_in = twice_ff + 1'b1;
               end else if (rd_use == mec_pkg::USE_TWO) begin
                  twice_in = twice_ff - 1'b1;
                  over_in  = over_ff + 1'b1;
               end
               held_in = 1'b0;
            end else if (exhausted) begin
               overflow_in = 1'b1;
               held_in     = 1'b0;
            end else begin
               slot_in   = slot_next;
               probe_in  = probe_ff + 1'b1;
               ram_re    = 1'b1;
               ram_raddr = slot_next;
            end
         end
         mec_pkg::B_RESULT: begin
            if (rsp_load) begin
               rsp_valid_in      = 1'b1;
               rsp_in.watertight = (distinct_ff == '0) || (twice_ff == distinct_ff);
               rsp_in.manifold   = (over_ff == '0);
               rsp_in.edge_total = mec_pkg::TOTAL_BITS'(distinct_ff);
               rsp_in.table_full = overflow_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mec_pkg::B_SWEEP;
         sweep_ff     <= '0;
         epoch_ff     <= mec_pkg::EPOCH_FIRST;
         held_ff      <= 1'b0;
         distinct_ff  <= '0;
         twice_ff     <= '0;
         over_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         held_ff      <= held_in;
         distinct_ff  <= distinct_in;
         twice_ff     <= twice_in;
         over_ff      <= over_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign used_sum = {1'b0, twice_ff} + {1'b0, over_ff};

   `MEC_ASSERT(a_counts_fit, clock, reset, used_sum <= {1'b0, distinct_ff}, "use counters exceed edge count")
   `MEC_ASSERT_IMPL(a_rsp_from_result, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == mec_pkg::B_RESULT, "result raised outside result state")
   `MEC_ASSERT_IMPL(a_sweep_no_pop, clock, reset, state_ff == mec_pkg::B_SWEEP, !(pop_valid && pop_ready) && !ram_re, "table access during clearing pass")

endmodule

[rtl/mesh_edge_use_checker.sv]
// Channel    | Ports                               | Moves
// request    | req_valid, req_ready, req_data      | one triangle and its restart bit
// response   | rsp_valid, rsp_ready, rsp_data      | one status word per triangle
//
// The front hashes each edge of a triangle through its MUL, ADD and PUSH states; a table
// depth that is not a power of two adds remainder steps (quotient, subtract, fix) in MOD.
// The back reads and checks each edge, plus a read per extra probe on a collision
// (one RAM port). After reset, and after every 15th restart, a clearing pass writes
// every slot while req_ready stays low.
// Either side may stall: a 4-entry edge queue and the response register decouple them.
module mesh_edge_use_checker #(
   parameter int VERTEX_BITS = mec_pkg::VERTEX_BITS_DEF,
   parameter int TABLE_DEPTH = mec_pkg::TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mec_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mec_pkg::rsp_type rsp_data
);

   localparam int VW = (VERTEX_BITS < mec_pkg::IN_BITS) ? VERTEX_BITS : mec_pkg::IN_BITS;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int FW = $bits(mec_pkg::edge_flags_type);
   localparam int QW = FW + 2 * VW + AW;

   logic                    sweeping;
   logic                    f_valid, f_ready, b_valid, b_ready;
   mec_pkg::edge_flags_type f_flags, b_flags;
   logic [2*VW-1:0]         f_key, b_key;
   logic [AW-1:0]           f_slot, b_slot;
   logic [QW-1:0]           q_in, q_out;

   // Front: accept triangles, hash edges
   mec_front #(
      .VERTEX_BITS (VERTEX_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (sweeping),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_flags (f_flags),
      .push_key   (f_key),
      .push_slot  (f_slot)
   );

   // Edge queue
   assign q_in = {f_flags, f_key, f_slot};

   mec_fifo #(
      .WIDTH (QW),
      .DEPTH (mec_pkg::FIFO_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (q_out)
   );

   assign b_flags = q_out[QW-1 -: FW];
   assign b_key   = q_out[AW +: 2*VW];
   assign b_slot  = q_out[AW-1:0];

   // Back: probe table, update counters, report
   mec_back #(
      .VERTEX_BITS (VERTEX_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .sweeping  (sweeping),
      .pop_valid (b_valid),
      .pop_ready (b_ready),
      .pop_flags (b_flags),
      .pop_key   (b_key),
      .pop_slot  (b_slot),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
